[rtl/lighting_group_level_tracker_macros.svh]
// Assertion macros for the lighting group level tracker.
// Included by modules that carry concurrent checks.
`ifndef LIGHTING_GROUP_LEVEL_TRACKER_MACROS_SVH
`define LIGHTING_GROUP_LEVEL_TRACKER_MACROS_SVH

// implication check under synchronous reset
`define LGLT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication check
`define LGLT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/lglt_pkg.sv]
// Package for the lighting group level tracker: payload structs, codes, ring bus.
// No dependencies.
`default_nettype none
package lglt_pkg;

  localparam int unsigned NumGroups = 16;

  typedef enum logic [1:0] {
    KIND_COMMAND = 2'd0,
    KIND_MEMBER  = 2'd1,
    KIND_QUERY   = 2'd2,
    KIND_UNUSED  = 2'd3
  } kind_t;

  localparam logic [7:0] CMD_DIRECT     = 8'd0;
  localparam logic [7:0] CMD_OFF        = 8'd1;
  localparam logic [7:0] CMD_RECALL_MAX = 8'd6;
  localparam logic [7:0] CMD_RECALL_MIN = 8'd7;

  localparam logic [7:0] DEST_BROADCAST = 8'hFF;
  localparam logic [7:0] GROUP_MASK     = 8'hE1;
  localparam logic [7:0] GROUP_MATCH    = 8'h81;
  localparam logic [7:0] INDIV_MASK     = 8'h81;
  localparam logic [7:0] INDIV_MATCH    = 8'h01;

  localparam logic       REG_MIN_LEVEL = 1'b0;
  localparam logic       REG_MAX_LEVEL = 1'b1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  dest_address;
    logic [7:0]  command;
    logic [7:0]  level;
    logic [5:0]  member_address;
    logic [15:0] member_groups;
    logic [3:0]  query_group;
  } in_item_t;

  typedef struct packed {
    logic [15:0] affected_groups;
    logic [6:0]  device_count;
    logic [6:0]  off_count;
    logic [7:0]  average_level;
    logic        notify;
  } out_item_t;

  // per-cell operation broadcast along the chain
  typedef struct packed {
    logic        wr_level;   // write level if selected
    logic        sel_all;    // broadcast select
    logic        sel_group;  // group select
    logic        sel_dev;    // individual select
    logic        wr_member;  // membership write
    logic        query;      // query pass
    logic [5:0]  dev;
    logic [3:0]  grp;
    logic [7:0]  value;
    logic [15:0] groups;
  } cell_op_t;

  // data rippled cell to cell, one hop per cycle
  typedef struct packed {
    logic        active;
    cell_op_t    op;
    logic [6:0]  count;
    logic [6:0]  off;
    logic [13:0] sum;
    logic [15:0] member;   // membership of addressed device
  } ring_t;

endpackage
`default_nettype wire

[rtl/lglt_cell.sv]
// One device cell: holds level, valid bit and group word; forwards the ring beat.
// Depends on lglt_pkg.
`default_nettype none
module lglt_cell
  import lglt_pkg::*;
#(
  parameter int unsigned Index = 0
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  ring_t      ring_in,
  output ring_t      ring_out
);

  logic [7:0]  level;
  logic        valid;
  logic [15:0] groups;
  logic        hit;
  logic        in_grp;
  ring_t       ring_next;

  always_comb begin
    hit = ring_in.op.sel_all
        || (ring_in.op.sel_group && groups[ring_in.op.grp])
        || (ring_in.op.sel_dev && ring_in.op.dev == 6'(Index));
    in_grp = groups[ring_in.op.grp] && valid;
    ring_next = ring_in;
    if (ring_in.op.query && in_grp) begin
      ring_next.count = ring_in.count + 7'd1;
      ring_next.sum   = ring_in.sum + 14'(level);
      if (level == 8'd0) begin
        ring_next.off = ring_in.off + 7'd1;
      end
    end
    if (ring_in.op.dev == 6'(Index)) begin
      ring_next.member = groups;
    end
  end

  always_ff @(posedge clk) begin
    if (ring_in.active && ring_in.op.wr_level && hit) begin
      level <= ring_in.op.value;
    end
    ring_out.op     <= ring_next.op;
    ring_out.count  <= ring_next.count;
    ring_out.off    <= ring_next.off;
    ring_out.sum    <= ring_next.sum;
    ring_out.member <= ring_next.member;
    if (rst) begin
      valid <= 1'b0;
      groups <= '0;
      ring_out.active <= 1'b0;
    end else begin
      ring_out.active <= ring_in.active;
      if (ring_in.active && ring_in.op.wr_level && hit) begin
        valid <= 1'b1;
      end
      if (ring_in.active && ring_in.op.wr_member && ring_in.op.dev == 6'(Index)) begin
        groups <= ring_in.op.groups;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/lglt_divider.sv]
// Restoring divider: 14-bit sum by 7-bit count, one quotient bit per cycle.
// Depends on lglt_pkg.
`default_nettype none
module lglt_divider
  import lglt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [13:0] dividend,
  input  wire logic [6:0]  divisor,
  output logic             done,
  output logic [7:0]       quotient
);

  logic [13:0] quo;
  logic [7:0]  rem;
  logic [6:0]  dvs;
  logic [3:0]  step;
  logic        busy;
  logic [7:0]  trial;
  logic [8:0]  diff;

  always_comb begin
    trial = {rem[6:0], quo[13]};
    diff  = {1'b0, trial} - {2'b00, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= 4'd0;
        quo  <= dividend;
        rem  <= '0;
        dvs  <= divisor;
      end else if (busy) begin
        if (diff[8]) begin
          rem <= trial;
          quo <= {quo[12:0], 1'b0};
        end else begin
          rem <= diff[7:0];
          quo <= {quo[12:0], 1'b1};
        end
        step <= step + 4'd1;
        if (step == 4'd13) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo[7:0];

endmodule
`default_nettype wire

[rtl/lighting_group_level_tracker.sv]
// Top level of the lighting group level tracker: decode, cell chain, divider, output.
// Depends on lglt_pkg, lglt_cell, lglt_divider and the macros header.
//
//  channel | valid     | ready     | payload
//  in      | in_valid  | in_ready  | in_item  (in_item_t)
//  out     | out_valid | out_ready | out_item (out_item_t)
//  cfg     | cfg_valid | cfg_ready | cfg_index, cfg_data
//
// One item at a time. Each item walks the chain of NUM_DEVICES cells, one cell a cycle;
// the result is registered once the walk leaves the last cell, and the next input beat is
// taken the cycle after the result beat; queries with members also run the divider first.
// Reset clears valid bits, group words and control; levels are written before read.
// The result sits in an output register; a stalled output holds the next item at the input.
`default_nettype none
`include "lighting_group_level_tracker_macros.svh"
module lighting_group_level_tracker
  import lglt_pkg::*;
#(
  parameter int unsigned NUM_DEVICES = 64
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_item_t out_item,
  input  wire logic cfg_valid,
  output logic      cfg_ready,
  input  wire logic cfg_index,
  input  wire logic [7:0] cfg_data
);

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_DIV, S_OUT} state_t;

  state_t      state;
  logic [7:0]  min_level;
  logic [7:0]  max_level;
  ring_t       ring [NUM_DEVICES+1];
  ring_t       head;
  in_item_t    item;
  logic        dev_ok;
  logic        div_start;
  logic        div_done;
  logic [7:0]  quotient;
  logic [6:0]  cnt_hold;
  logic [6:0]  off_hold;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    logic known;
    logic [7:0] value;
    logic is_bc;
    logic is_grp;
    logic is_dev;
    known = 1'b1;
    value = 8'd0;
    unique case (in_item.command)
      CMD_OFF:        value = 8'd0;
      CMD_RECALL_MIN: value = min_level;
      CMD_RECALL_MAX: value = max_level;
      CMD_DIRECT:     value = in_item.level;
      default:        known = 1'b0;
    endcase
    is_bc  = in_item.dest_address == DEST_BROADCAST;
    is_grp = !is_bc && ((in_item.dest_address & GROUP_MASK) == GROUP_MATCH);
    is_dev = !is_bc && !is_grp && ((in_item.dest_address & INDIV_MASK) == INDIV_MATCH);
    head = '0;
    head.active = in_valid && in_ready;
    head.op.value = value;
    head.op.groups = in_item.member_groups;
    if (in_item.kind == KIND_COMMAND) begin
      head.op.wr_level  = known;
      head.op.sel_all   = is_bc;
      head.op.sel_group = is_grp;
      head.op.sel_dev   = is_dev;
      head.op.grp       = in_item.dest_address[4:1];
      head.op.dev       = is_dev ? in_item.dest_address[6:1] : 6'd63;
    end else if (in_item.kind == KIND_MEMBER) begin
      head.op.wr_member = 1'b1;
      head.op.dev       = in_item.member_address;
    end else if (in_item.kind == KIND_QUERY) begin
      head.op.query = 1'b1;
      head.op.grp   = in_item.query_group;
      head.op.dev   = 6'd63;
    end else begin
      head.op.dev = 6'd63;
    end
  end

  assign ring[0] = head;

  for (genvar i = 0; i < NUM_DEVICES; i++) begin : g_cell
    lglt_cell #(.Index(i)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ring_in  (ring[i]),
      .ring_out (ring[i+1])
    );
  end

  assign dev_ok = 7'(item.dest_address[6:1]) < 7'(NUM_DEVICES);

  lglt_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (ring[NUM_DEVICES].sum),
    .divisor  (ring[NUM_DEVICES].count),
    .done     (div_done),
    .quotient (quotient)
  );

  assign div_start = (state == S_WALK) && ring[NUM_DEVICES].active
                   && item.kind == KIND_QUERY && ring[NUM_DEVICES].count != 7'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      min_level <= 8'd1;
      max_level <= 8'd254;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_MIN_LEVEL: min_level <= cfg_data;
          REG_MAX_LEVEL: max_level <= cfg_data;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            item  <= in_item;
            state <= S_WALK;
          end
        end
        S_WALK: begin
          if (ring[NUM_DEVICES].active) begin
            out_item <= '0;
            if (item.kind == KIND_COMMAND) begin
              out_item.notify <= 1'b1;
              if (item.dest_address == DEST_BROADCAST) begin
                out_item.affected_groups <= 16'hFFFF;
              end else if ((item.dest_address & GROUP_MASK) == GROUP_MATCH) begin
                out_item.affected_groups <= 16'(1) << item.dest_address[4:1];
              end else if ((item.dest_address & INDIV_MASK) == INDIV_MATCH && dev_ok) begin
                out_item.affected_groups <= ring[NUM_DEVICES].member;
              end
            end
            if (item.kind == KIND_QUERY && ring[NUM_DEVICES].count != 7'd0) begin
              cnt_hold <= ring[NUM_DEVICES].count;
              off_hold <= ring[NUM_DEVICES].off;
              state    <= S_DIV;
            end else begin
              out_valid <= 1'b1;
              state     <= S_OUT;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            out_item.device_count  <= cnt_hold;
            out_item.off_count     <= off_hold;
            out_item.average_level <= quotient;
            out_valid <= 1'b1;
            state     <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `LGLT_ASSERT_IMP(a_out_only_in_out, clk, rst, out_valid, state == S_OUT, "out_valid outside S_OUT")
  `LGLT_ASSERT_NEXT(a_accept_walks, clk, rst, in_valid && in_ready, state == S_WALK, "accept did not start walk")
  `LGLT_ASSERT_IMP(a_div_in_div, clk, rst, div_done, state == S_DIV, "divider finished outside S_DIV")

endmodule
`default_nettype wire

[bench/tb_lighting_group_level_tracker.sv]
// Testbench for the lighting group level tracker: random and directed beats, scoreboard check.
// Depends on lglt_pkg and the lighting_group_level_tracker RTL.
`timescale 1ns / 1ps
module tb_lighting_group_level_tracker;
  import lglt_pkg::*;

  localparam int NDEV = 64;
  localparam int InW = $bits(in_item_t);

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic [7:0] cfg_data = '0;

  lighting_group_level_tracker #(.NUM_DEVICES(NDEV)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  logic [7:0] min_lvl, max_lvl;
  logic [7:0] dev_level [NDEV];
  logic dev_valid [NDEV];
  logic [15:0] dev_groups [NDEV];

  in_item_t pending_items[$];
  out_item_t expected_results[$];
  int errors = 0;
  int n_checked = 0;
  bit quiet = 1'b0;
  bit hold_sender = 1'b0;

  function automatic out_item_t track_item(in_item_t it);
    out_item_t r;
    logic [7:0] v;
    bit known;
    int cnt, off, sum, d;
    logic [3:0] g;
    r = '0;
    case (kind_t'(it.kind))
      KIND_COMMAND: begin
        known = 1'b1;
        v = '0;
        if (it.command == CMD_OFF) v = '0;
        else if (it.command == CMD_RECALL_MIN) v = min_lvl;
        else if (it.command == CMD_RECALL_MAX) v = max_lvl;
        else if (it.command == CMD_DIRECT) v = it.level;
        else known = 1'b0;
        if (it.dest_address == DEST_BROADCAST) begin
          r.affected_groups = '1;
          if (known) for (int n = 0; n < NDEV; n++) begin
            dev_level[n] = v; dev_valid[n] = 1'b1;
          end
        end else if ((it.dest_address & GROUP_MASK) == GROUP_MATCH) begin
          g = it.dest_address[4:1];
          r.affected_groups = 16'd1 << g;
          if (known) for (int n = 0; n < NDEV; n++)
            if (dev_groups[n][g]) begin
              dev_level[n] = v; dev_valid[n] = 1'b1;
            end
        end else if ((it.dest_address & INDIV_MASK) == INDIV_MATCH) begin
          d = it.dest_address[6:1];
          if (d < NDEV) begin
            r.affected_groups = dev_groups[d];
            if (known) begin
              dev_level[d] = v; dev_valid[d] = 1'b1;
            end
          end
        end
        r.notify = 1'b1;
      end
      KIND_MEMBER: begin
        if (it.member_address < NDEV) dev_groups[it.member_address] = it.member_groups;
      end
      KIND_QUERY: begin
        cnt = 0; off = 0; sum = 0;
        for (int n = 0; n < NDEV; n++)
          if (dev_groups[n][it.query_group] && dev_valid[n]) begin
            cnt++; sum += dev_level[n];
            if (dev_level[n] == 0) off++;
          end
        r.device_count = cnt[6:0];
        r.off_count = off[6:0];
        r.average_level = cnt ? 8'(sum / cnt) : 8'd0;
      end
      default: ;
    endcase
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_ready) begin
    end else if (pending_items.size() > 0 && !hold_sender &&
                 (quiet || $urandom_range(99) >= 6)) begin
      if (in_valid && in_ready) expected_results.push_back(track_item(in_item));
      in_item <= pending_items.pop_front();
      in_valid <= 1'b1;
    end else begin
      if (in_valid && in_ready) expected_results.push_back(track_item(in_item));
      in_valid <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_item);
          errors++;
        end else begin
          out_item_t e;
          e = expected_results.pop_front();
          n_checked++;
          if (out_item.affected_groups !== e.affected_groups)
            $display("%0t: affected_groups exp %h got %h", $time, e.affected_groups,
                     out_item.affected_groups);
          if (out_item.device_count !== e.device_count)
            $display("%0t: device_count exp %0d got %0d", $time, e.device_count,
                     out_item.device_count);
          if (out_item.off_count !== e.off_count)
            $display("%0t: off_count exp %0d got %0d", $time, e.off_count, out_item.off_count);
          if (out_item.average_level !== e.average_level)
            $display("%0t: average_level exp %0d got %0d", $time, e.average_level,
                     out_item.average_level);
          if (out_item.notify !== e.notify)
            $display("%0t: notify exp %b got %b", $time, e.notify, out_item.notify);
          if (out_item !== e) errors++;
        end
      end
      out_ready <= quiet || $urandom_range(99) >= 6;
    end
  end

  function automatic in_item_t rand_beat();
    in_item_t it;
    int sel;
    it = in_item_t'(InW'({$urandom, $urandom}));
    sel = $urandom_range(99);
    if (sel < 45) begin
      it.kind = KIND_COMMAND;
      case ($urandom_range(9))
        0: it.dest_address = DEST_BROADCAST;
        1, 2, 3: it.dest_address = {3'b100, 4'($urandom), 1'($urandom)};
        4, 5, 6, 7: it.dest_address = {1'b0, 6'($urandom), 1'($urandom)};
        default: ;
      endcase
      case ($urandom_range(9))
        0, 1, 2, 3: it.command = CMD_DIRECT;
        4: it.command = CMD_OFF;
        5: it.command = CMD_RECALL_MAX;
        6: it.command = CMD_RECALL_MIN;
        default: ;
      endcase
    end else if (sel < 65) begin
      it.kind = KIND_MEMBER;
    end else if (sel < 97) begin
      it.kind = KIND_QUERY;
    end else begin
      it.kind = KIND_UNUSED;
    end
    return it;
  endfunction

  function automatic in_item_t mk(kind_t k, logic [7:0] dst, logic [7:0] cmd,
                                  logic [7:0] lvl, logic [5:0] ma, logic [15:0] mg,
                                  logic [3:0] qg);
    in_item_t it;
    it.kind = k; it.dest_address = dst; it.command = cmd; it.level = lvl;
    it.member_address = ma; it.member_groups = mg; it.query_group = qg;
    return it;
  endfunction

  task automatic drain();
    while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [7:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_MIN_LEVEL) min_lvl = val;
    else max_lvl = val;
  endtask

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) pending_items.push_back(rand_beat());
  endtask

  initial begin
    min_lvl = 8'd1;
    max_lvl = 8'd254;
    for (int n = 0; n < NDEV; n++) begin
      dev_level[n] = '0; dev_valid[n] = 1'b0; dev_groups[n] = '0;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed
    pending_items.push_back(mk(KIND_QUERY, 0, 0, 0, 0, 0, 4'd0));
    pending_items.push_back(mk(KIND_MEMBER, 0, 0, 0, 6'd0, 16'hFFFF, 0));
    pending_items.push_back(mk(KIND_MEMBER, 0, 0, 0, 6'd63, 16'h8001, 0));
    pending_items.push_back(mk(KIND_MEMBER, 0, 0, 0, 6'd5, 16'h0000, 0));
    pending_items.push_back(mk(KIND_COMMAND, 8'h01, CMD_DIRECT, 8'hFF, 0, 0, 0));
    pending_items.push_back(mk(KIND_COMMAND, 8'h7F, CMD_OFF, 0, 0, 0, 0));
    pending_items.push_back(mk(KIND_QUERY, 0, 0, 0, 0, 0, 4'd15));
    pending_items.push_back(mk(KIND_COMMAND, 8'h81, CMD_RECALL_MAX, 0, 0, 0, 0));
    pending_items.push_back(mk(KIND_COMMAND, 8'h9F, CMD_RECALL_MIN, 0, 0, 0, 0));
    pending_items.push_back(mk(KIND_COMMAND, 8'h81, 8'hFF, 8'h55, 0, 0, 0));
    pending_items.push_back(mk(KIND_COMMAND, 8'hC3, CMD_DIRECT, 8'h10, 0, 0, 0));
    pending_items.push_back(mk(KIND_COMMAND, 8'h80, CMD_DIRECT, 8'h10, 0, 0, 0));
    pending_items.push_back(mk(KIND_QUERY, 0, 0, 0, 0, 0, 4'd0));
    pending_items.push_back(mk(KIND_COMMAND, DEST_BROADCAST, CMD_DIRECT, 8'h80, 0, 0, 0));
    pending_items.push_back(mk(KIND_QUERY, 0, 0, 0, 0, 0, 4'd0));
    pending_items.push_back(mk(KIND_COMMAND, DEST_BROADCAST, CMD_OFF, 0, 0, 0, 0));
    pending_items.push_back(mk(KIND_QUERY, 0, 0, 0, 0, 0, 4'd15));
    pending_items.push_back(mk(KIND_COMMAND, DEST_BROADCAST, 8'h42, 0, 0, 0, 0));
    pending_items.push_back(mk(KIND_UNUSED, 8'hFF, 8'hFF, 8'hFF, 6'h3F, 16'hFFFF, 4'hF));
    pending_items.push_back(mk(KIND_COMMAND, DEST_BROADCAST, CMD_RECALL_MAX, 0, 0, 0, 0));
    pending_items.push_back(mk(KIND_QUERY, 0, 0, 0, 0, 0, 4'd7));
    drain();

    write_reg(REG_MIN_LEVEL, 8'd0);
    write_reg(REG_MAX_LEVEL, 8'd255);
    random_phase(200);
    hold_sender = 1'b1;
    while (in_valid || expected_results.size() > 0) @(posedge clk);
    hold_sender = 1'b0;
    drain();

    write_reg(REG_MIN_LEVEL, 8'd254);
    write_reg(REG_MAX_LEVEL, 8'd0);
    quiet = 1'b1;
    random_phase(200);
    drain();
    quiet = 1'b0;

    write_reg(REG_MIN_LEVEL, 8'($urandom));
    write_reg(REG_MAX_LEVEL, 8'($urandom));
    random_phase(300);
    drain();

    $display("Checked %0d results: directed cases, 700 random beats, four register settings.",
             n_checked);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #20ms;
    $display("Timeout.");
    $display("== FAIL ==");
    $finish;
  end

endmodule

[lighting_group_level_tracker.f]
+incdir+rtl
rtl/lglt_pkg.sv
rtl/lglt_cell.sv
rtl/lglt_divider.sv
rtl/lighting_group_level_tracker.sv
bench/tb_lighting_group_level_tracker.sv
